// File: rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and codes for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_INIT   = 2'd1;
  localparam logic [1:0] KIND_CLEAN  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RUN  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [1:0] CFG_ZONE_FIRST = 2'd0;
  localparam logic [1:0] CFG_ZONE_LAST  = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] page_index;
    logic [6:0] run_length;
    logic [7:0] page_flags;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  first_page;
    logic [10:0] free_count;
  } rsp_t;

  typedef enum logic [1:0] {
    FIRST_ZERO = 2'd0,
    FIRST_PAGE = 2'd1,
    FIRST_RUN  = 2'd2
  } first_src_t;

  typedef struct packed {
    logic       clr_step;
    logic       capture;
    logic       scan_start;
    logic       fetch;
    logic       scan_step;
    logic       pg_start_alloc;
    logic       pg_start_single;
    logic       pg_read;
    logic       pg_write;
    logic       res_set;
    logic [1:0] res_status;
    first_src_t res_first;
    logic       load_rsp;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] kind;
    logic       alloc_ok;
    logic       page_in_zone;
    logic       found;
    logic       chunk_last;
    logic       word_end;
    logic       pg_last;
    logic       rsp_free;
  } sts_t;

endpackage

// File: rtl/pba_ctrl.sv
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer for the allocator: clearing pass, decode, scan and page updates.
// ----------------------------------------------------------------------------
module pba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pba_pkg::sts_t sts,
  output pba_pkg::cmd_t cmd
);
  import pba_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_FETCH  = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_PG_RD  = 8'b0010_0000,
    S_PG_WR  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_set = 1'b1;
        case (sts.kind)
          KIND_ALLOC: begin
            if (sts.alloc_ok) begin
              cmd.res_set    = 1'b0;
              cmd.scan_start = 1'b1;
              state_next     = S_FETCH;
            end else begin
              cmd.res_status = ST_NO_RUN;
              cmd.res_first  = FIRST_ZERO;
              state_next     = S_DONE;
            end
          end
          KIND_INIT, KIND_CLEAN: begin
            cmd.res_first = FIRST_PAGE;
            if (sts.page_in_zone) begin
              cmd.res_status      = ST_OK;
              cmd.pg_start_single = 1'b1;
              state_next          = S_PG_RD;
            end else begin
              cmd.res_status = ST_OUTSIDE;
              state_next     = S_DONE;
            end
          end
          default: begin
            cmd.res_status = ST_OK;
            cmd.res_first  = FIRST_ZERO;
            state_next     = S_DONE;
          end
        endcase
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          cmd.pg_start_alloc = 1'b1;
          cmd.res_set        = 1'b1;
          cmd.res_status     = ST_OK;
          cmd.res_first      = FIRST_RUN;
          state_next         = S_PG_RD;
        end else if (sts.chunk_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NO_RUN;
          cmd.res_first  = FIRST_ZERO;
          state_next     = S_DONE;
        end else if (sts.word_end) begin
          state_next = S_FETCH;
        end
      end
      S_PG_RD: begin
        cmd.pg_read = 1'b1;
        state_next  = S_PG_WR;
      end
      S_PG_WR: begin
        cmd.pg_write = 1'b1;
        state_next   = sts.pg_last ? S_DONE : S_PG_RD;
      end
      S_DONE: begin
        if (sts.rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/pba_datapath.sv
// ----------------------------------------------------------------------------
// pba_datapath
// Zone registers, bitmap and page memories, run scanner and page update logic.
// ----------------------------------------------------------------------------
module pba_datapath #(
  parameter int NUM_PAGES      = 1024,
  parameter int MAX_RUN        = 64,
  parameter int REFERENCED_BIT = 0,
  parameter int SHARED_BIT     = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  pba_pkg::cmd_t cmd,
  output pba_pkg::sts_t sts,
  input  pba_pkg::req_t req,
  output pba_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [9:0]    cfg_data
);
  import pba_pkg::*;

  localparam int WORDS   = (NUM_PAGES + 63) / 64;
  localparam int AW      = $clog2(NUM_PAGES);
  localparam int WA      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LAST_PG = (NUM_PAGES - 1 > 1023) ? 1023 : NUM_PAGES - 1;

  localparam logic [10:0] USING_MAX = 11'h7FF;
  localparam logic [19:0] REFS_MAX  = 20'hFFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  logic [9:0]  zone_first, zone_last;
  req_t        rq;
  logic [10:0] pages_used;
  logic [19:0] total_refs;
  logic [9:0]  cur;
  logic [6:0]  run;
  logic [9:0]  ptr;
  logic [6:0]  rem;
  logic [AW-1:0] clr_cnt;
  logic [1:0]  res_status;
  logic [9:0]  res_first;

  logic [63:0] bm_mem [WORDS];
  logic [23:0] pm_mem [NUM_PAGES];
  logic [63:0] bm_q;
  logic [23:0] pm_q;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_first <= 10'd0;
      zone_last  <= 10'd1023;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ZONE_FIRST) zone_first <= cfg_data;
      if (cfg_index == CFG_ZONE_LAST)  zone_last  <= cfg_data;
    end
  end

  // Zone geometry and free count
  logic [9:0]  zone_top;
  logic [10:0] zone_size, free_cnt;
  always_comb begin
    zone_top  = (zone_last > 10'(LAST_PG)) ? 10'(LAST_PG) : zone_last;
    zone_size = (zone_first > zone_top) ? 11'd0 :
                ({1'b0, zone_top} - {1'b0, zone_first} + 11'd1);
    free_cnt  = (zone_size > pages_used) ? (zone_size - pages_used) : 11'd0;
  end

  // Chunk scanner: eight pages a step, a page outside the zone breaks a run.
  logic [6:0] run_n;
  logic       found;
  logic [9:0] found_pg, run_start;
  logic [10:0] start_sum;
  always_comb begin
    logic [9:0] p;
    logic       u;
    run_n    = run;
    found    = 1'b0;
    found_pg = cur;
    for (int j = 0; j < 8; j++) begin
      p = {cur[9:3], 3'(j)};
      u = bm_q[{cur[5:3], 3'(j)}] || (p < zone_first) || (p > zone_top);
      if (!found) begin
        run_n = u ? 7'd0 : run_n + 7'd1;
        if (run_n == rq.run_length) begin
          found    = 1'b1;
          found_pg = p;
        end
      end
    end
    start_sum = {1'b0, found_pg} + 11'd1 - {4'd0, rq.run_length};
    run_start = start_sum[9:0];
  end

  // Page update for init and clean
  logic [7:0]  a_new;
  logic [15:0] c_new;
  logic        b_new;
  logic [10:0] using_new;
  logic [19:0] refs_new;
  logic [63:0] bm_wdata;
  always_comb begin
    logic [7:0]  a;
    logic [15:0] c;
    logic        sh_old, sh_flag;
    a         = pm_q[23:16];
    c         = pm_q[15:0];
    sh_old    = a[3'(REFERENCED_BIT)] | a[3'(SHARED_BIT)];
    sh_flag   = rq.page_flags[3'(REFERENCED_BIT)] | rq.page_flags[3'(SHARED_BIT)];
    a_new     = a;
    c_new     = c;
    b_new     = bm_q[ptr[5:0]];
    using_new = pages_used;
    refs_new  = total_refs;
    if (rq.kind == KIND_CLEAN) begin
      if (a != 8'd0) begin
        if (total_refs != 20'd0) refs_new = total_refs - 20'd1;
        if (sh_old) begin
          if (c != 16'd0) c_new = c - 16'd1;
        end else begin
          c_new = 16'd0;
        end
        if (!sh_old || c_new == 16'd0) begin
          b_new = 1'b0;
          a_new = 8'd0;
          if (pages_used != 11'd0) using_new = pages_used - 11'd1;
        end
      end
    end else begin
      if (a == 8'd0) begin
        b_new = 1'b1;
        a_new = rq.page_flags;
        if (c != COUNT_MAX) c_new = c + 16'd1;
        if (total_refs != REFS_MAX) refs_new = total_refs + 20'd1;
        if (pages_used != USING_MAX) using_new = pages_used + 11'd1;
      end else if (sh_old || sh_flag) begin
        a_new = a | rq.page_flags;
        if (c != COUNT_MAX) c_new = c + 16'd1;
        if (total_refs != REFS_MAX) refs_new = total_refs + 20'd1;
      end else begin
        b_new = 1'b1;
        a_new = a | rq.page_flags;
      end
    end
    bm_wdata           = bm_q;
    bm_wdata[ptr[5:0]] = b_new;
  end

  // Memories: one registered read port and one write port each.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      bm_q <= bm_mem[WA'(cur[9:6])];
    end else if (cmd.pg_read) begin
      bm_q <= bm_mem[WA'(ptr[9:6])];
    end
    if (cmd.pg_read) pm_q <= pm_mem[AW'(ptr)];
    if (cmd.clr_step) begin
      pm_mem[clr_cnt] <= 24'd0;
      if (32'(clr_cnt) < WORDS) bm_mem[WA'(clr_cnt)] <= 64'd0;
    end else if (cmd.pg_write) begin
      pm_mem[AW'(ptr)]       <= {a_new, c_new};
      bm_mem[WA'(ptr[9:6])] <= bm_wdata;
    end
  end

  // Control and counters; the clearing counter stops on the last entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      pages_used <= 11'd0;
      total_refs <= 20'd0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.clr_step && !sts.clr_done) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.pg_write) begin
        pages_used <= using_new;
        total_refs <= refs_new;
      end
      if (cmd.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request, scan and run registers
  always_ff @(posedge clk) begin
    if (cmd.capture) rq <= req;
    if (cmd.scan_start) begin
      cur <= {zone_first[9:3], 3'd0};
      run <= 7'd0;
    end else if (cmd.scan_step) begin
      cur <= cur + 10'd8;
      run <= run_n;
    end
    if (cmd.pg_start_alloc) begin
      ptr <= run_start;
      rem <= rq.run_length;
    end else if (cmd.pg_start_single) begin
      ptr <= rq.page_index;
      rem <= 7'd1;
    end else if (cmd.pg_write) begin
      ptr <= ptr + 10'd1;
      rem <= rem - 7'd1;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      case (cmd.res_first)
        FIRST_PAGE: res_first <= rq.page_index;
        FIRST_RUN:  res_first <= run_start;
        default:    res_first <= 10'd0;
      endcase
    end
    if (cmd.load_rsp) begin
      rsp.status     <= res_status;
      rsp.first_page <= res_first;
      rsp.free_count <= free_cnt;
    end
  end

  always_comb begin
    sts.clr_done     = (clr_cnt == AW'(NUM_PAGES - 1));
    sts.kind         = rq.kind;
    sts.alloc_ok     = (rq.run_length >= 7'd1) && (rq.run_length <= 7'(MAX_RUN)) &&
                       (free_cnt >= {4'd0, rq.run_length}) && (zone_size != 11'd0);
    sts.page_in_zone = (rq.page_index >= zone_first) && (rq.page_index <= zone_top);
    sts.found        = found;
    sts.chunk_last   = (cur[9:3] == zone_top[9:3]);
    sts.word_end     = (cur[5:3] == 3'b111);
    sts.pg_last      = (rem == 7'd1);
    sts.rsp_free     = !rsp_valid || !rsp_stall;
  end

`ifndef ASSERT_OFF
  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    cmd.pg_write |-> sts.clr_done)
    else $error("page update during clearing pass");
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.pg_write |-> rem != 7'd0)
    else $error("page update with no pages left");
  a_run_in_zone: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && found) |-> (run_start >= zone_first && found_pg <= zone_top))
    else $error("allocated run outside zone");
`endif

endmodule

// File: rtl/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// First-fit page allocator with per-page flags and reference counts.
// ----------------------------------------------------------------------------
// Requests arrive on req (req_valid/req_stall); one beat gives one result
// beat on rsp (rsp_valid/rsp_stall). Zone bounds are written on the cfg
// port (index 0 first page, index 1 last page); the user is to write them
// only while the block is idle, which the block itself does not enforce.
// After reset a clearing pass writes every page entry, with req_stall high
// throughout. Init and clean go through decode, a page read and a page
// write before their result is loaded; rejected requests and unknown kinds
// go from decode straight to the result. An allocate scans the zone eight
// pages a cycle, pausing for one bitmap word fetch per 64 pages, then does
// a read-modify-write of the page memory, a read state and then a write
// state, for each page of the run.
// One request is handled at a time; the next is taken once the result is
// in the output register. While the receiver stalls, the result is held
// and a finished second request waits for the register to empty.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
  parameter int NUM_PAGES      = 1024,
  parameter int MAX_RUN        = 64,
  parameter int REFERENCED_BIT = 0,
  parameter int SHARED_BIT     = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pba_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [9:0]    cfg_data
);
  import pba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pba_datapath #(
    .NUM_PAGES      (NUM_PAGES),
    .MAX_RUN        (MAX_RUN),
    .REFERENCED_BIT (REFERENCED_BIT),
    .SHARED_BIT     (SHARED_BIT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// File: test/page_bitmap_allocator_tb.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_tb
// Self-checking bench for the first-fit page allocator.
// ----------------------------------------------------------------------------
// Requests are driven with random gaps and the response side stalls at
// random. A behavioural copy of the allocator state predicts each response,
// and a scoreboard compares every response beat against the oldest
// prediction. Zone bounds are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  localparam int NPAGES = 1024;
  localparam int RUN_MAX = 64;
  localparam int REF_B = 0;
  localparam int SHR_B = 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_ZONE_FIRST;
  logic [9:0] cfg_data = '0;

  int err_count = 0;
  int stall_pct = 33;
  int hold_off = 0;

  always #6 clk = ~clk;

  page_bitmap_allocator u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  class rsp_scoreboard;
    rsp_t pending[$];

    function void note(input req_t r);
      pending.push_back(serve_request(r));
    endfunction

    task check(input rsp_t r);
      rsp_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", r.first_page, 0);
        return;
      end
      e = pending.pop_front();
      if (r.status !== e.status) report("status", r.status, e.status);
      if (r.first_page !== e.first_page) report("first_page", r.first_page, e.first_page);
      if (r.free_count !== e.free_count) report("free_count", r.free_count, e.free_count);
    endtask
  endclass

  rsp_scoreboard sb = new();

  // Predicted allocator state.
  int unsigned zfirst = 0, zlast = 1023;
  bit used_map[NPAGES];
  bit [7:0] attr[NPAGES];
  int unsigned refcnt[NPAGES];
  int unsigned using_cnt = 0, refs_total = 0;

  function automatic int unsigned zone_size();
    int unsigned e;
    e = (zlast > NPAGES - 1) ? NPAGES - 1 : zlast;
    return (zfirst > e) ? 0 : e - zfirst + 1;
  endfunction

  function automatic int unsigned pages_free();
    int unsigned s;
    s = zone_size();
    return (s > using_cnt) ? s - using_cnt : 0;
  endfunction

  function automatic bit refd_or_shared(input bit [7:0] a);
    return a[REF_B] | a[SHR_B];
  endfunction

  function automatic void bump_ref(input int p);
    if (refcnt[p] < 65535) refcnt[p]++;
    if (refs_total < 1048575) refs_total++;
  endfunction

  function automatic void take_page(input int p, input bit [7:0] fl);
    bit [7:0] a;
    a = attr[p];
    if (a == 0) begin
      used_map[p] = 1'b1;
      attr[p] = fl;
      bump_ref(p);
      if (using_cnt < 2047) using_cnt++;
    end else if (refd_or_shared(a) || refd_or_shared(fl)) begin
      attr[p] = a | fl;
      bump_ref(p);
    end else begin
      used_map[p] = 1'b1;
      attr[p] = a | fl;
    end
  endfunction

  function automatic void release_page(input int p);
    bit [7:0] a;
    a = attr[p];
    if (a == 0) return;
    if (refs_total > 0) refs_total--;
    if (refd_or_shared(a)) begin
      if (refcnt[p] > 0) refcnt[p]--;
      if (refcnt[p] != 0) return;
    end else begin
      refcnt[p] = 0;
    end
    used_map[p] = 1'b0;
    attr[p] = 0;
    if (using_cnt > 0) using_cnt--;
  endfunction

  function automatic rsp_t serve_request(input req_t r);
    rsp_t o;
    int unsigned e, run, len, s;
    o = '0;
    len = r.run_length;
    if (r.kind == KIND_ALLOC) begin
      o.status = ST_NO_RUN;
      if (len >= 1 && len <= RUN_MAX && pages_free() >= len && zone_size() > 0) begin
        e = (zlast > NPAGES - 1) ? NPAGES - 1 : zlast;
        run = 0;
        for (int unsigned p = zfirst; p <= e; p++) begin
          run = used_map[p] ? 0 : run + 1;
          if (run == len) begin
            s = p + 1 - len;
            for (int unsigned q = 0; q < len; q++) take_page(s + q, r.page_flags);
            o.status = ST_OK;
            o.first_page = 10'(s);
            break;
          end
        end
      end
    end else if (r.kind == KIND_INIT || r.kind == KIND_CLEAN) begin
      o.first_page = r.page_index;
      if (r.page_index < zfirst || r.page_index > zlast) o.status = ST_OUTSIDE;
      else if (r.kind == KIND_INIT) take_page(r.page_index, r.page_flags);
      else release_page(r.page_index);
    end
    o.free_count = 11'(pages_free());
    return o;
  endfunction

  // Response side: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check(rsp);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send(input req_t r);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note(r);
    if ($urandom_range(99) < stall_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_zone(input logic [1:0] idx, input int unsigned v);
    cfg_index <= idx;
    cfg_data <= 10'(v);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ZONE_FIRST) zfirst = v;
    else zlast = v;
  endtask

  function automatic req_t mk(input logic [1:0] k, input int pg, input int len,
                              input int fl);
    req_t r;
    r.kind = k;
    r.page_index = 10'(pg);
    r.run_length = 7'(len);
    r.page_flags = 8'(fl);
    return r;
  endfunction

  function automatic req_t random_req();
    int unsigned sel;
    int unsigned lo, hi;
    sel = $urandom_range(99);
    lo = (zfirst > 0 && $urandom_range(3) == 0) ? zfirst - 1 : zfirst;
    hi = zlast + (($urandom_range(3) == 0 && zlast < 1023) ? 1 : 0);
    if (hi < lo) hi = lo;
    if (sel < 40)
      return mk(KIND_ALLOC, $urandom, ($urandom_range(9) == 0) ? $urandom_range(64, 1)
                : $urandom_range(8, 1), $urandom);
    else if (sel < 65)
      return mk(KIND_INIT, $urandom_range(hi, lo), $urandom_range(64, 1), $urandom);
    else if (sel < 97)
      return mk(KIND_CLEAN, $urandom_range(hi, lo), $urandom, $urandom);
    return mk(2'($urandom_range(3)), $urandom, $urandom, $urandom);
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send(random_req());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    send(mk(KIND_ALLOC, 0, 0, 8'h00));
    send(mk(KIND_ALLOC, 0, 65, 8'h00));
    send(mk(KIND_ALLOC, 0, 127, 8'hff));
    send(mk(KIND_ALLOC, 1023, 1, 8'h04));
    send(mk(KIND_ALLOC, 0, 64, 8'h02));
    send(mk(KIND_INIT, 2, 1, 8'h00));
    send(mk(KIND_INIT, 100, 1, 8'h00));
    send(mk(KIND_INIT, 100, 1, 8'h08));
    send(mk(KIND_INIT, 100, 1, 8'h01));
    send(mk(KIND_INIT, 1, 1, 8'h02));
    send(mk(KIND_CLEAN, 1, 0, 8'h00));
    send(mk(KIND_CLEAN, 1, 0, 8'h00));
    send(mk(KIND_CLEAN, 0, 0, 8'h00));
    send(mk(KIND_CLEAN, 100, 0, 8'h00));
    send(mk(KIND_CLEAN, 500, 0, 8'h00));
    send(mk(KIND_INIT, 1023, 1, 8'hff));
    send(mk(KIND_CLEAN, 1023, 0, 8'hff));
    send(mk(KIND_UNUSED, 1023, 127, 8'hff));
    send(mk(KIND_ALLOC, 0, 64, 8'h10));

    // Receiver holds off while requests keep coming.
    hold_off = 400;
    random_phase(20);
    go_idle();

    write_zone(CFG_ZONE_FIRST, 1000);
    write_zone(CFG_ZONE_LAST, 1023);
    send(mk(KIND_INIT, 999, 1, 8'h00));
    send(mk(KIND_ALLOC, 0, 30, 8'h00));
    random_phase(300);
    go_idle();

    write_zone(CFG_ZONE_FIRST, 1023);
    write_zone(CFG_ZONE_LAST, 0);
    send(mk(KIND_ALLOC, 0, 1, 8'h00));
    send(mk(KIND_INIT, 0, 1, 8'h00));
    random_phase(40);
    go_idle();

    write_zone(CFG_ZONE_FIRST, 0);
    write_zone(CFG_ZONE_LAST, 127);
    stall_pct = 0;
    random_phase(300);
    stall_pct = 33;
    random_phase(300);
    go_idle();

    write_zone(CFG_ZONE_FIRST, $urandom_range(300));
    write_zone(CFG_ZONE_LAST, $urandom_range(1023, 400));
    random_phase(400);
    go_idle();

    write_zone(CFG_ZONE_FIRST, 0);
    write_zone(CFG_ZONE_LAST, 1023);
    random_phase(440);
    go_idle();

    if (err_count == 0 && sb.pending.size() == 0) begin
      $display("page_bitmap_allocator_tb: clean");
    end else begin
      $display("page_bitmap_allocator_tb: errors");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("page_bitmap_allocator_tb: errors");
    $finish;
  end
endmodule

// File: sim.f
rtl/pba_pkg.sv
rtl/pba_ctrl.sv
rtl/pba_datapath.sv
rtl/page_bitmap_allocator.sv
test/page_bitmap_allocator_tb.sv
